[src/assert_macros.svh]
// assertion macros for the backoff block
// expects clk and arst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, off while in reset
`define DCEB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define DCEB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/dceb_pkg.sv]
// shared constants and helpers for the dual-class backoff block
// no dependencies
package dceb_pkg;

	localparam int TIME_WIDTH = 32;
	localparam int DATA_W     = 32;
	localparam int KIND_W     = 3;
	localparam int ADDR_W     = 5;
	localparam int REG_IDX_W  = 3;

	localparam logic [DATA_W-1:0] TIME_MASK = (TIME_WIDTH >= DATA_W) ? {DATA_W{1'b1}} :
		DATA_W'((64'd1 << TIME_WIDTH) - 64'd1);

	typedef logic [KIND_W-1:0] kind_t;
	typedef logic [1:0] class_t;

	localparam kind_t KIND_SYSTEM          = 3'd0;
	localparam kind_t KIND_CONNECT         = 3'd1;
	localparam kind_t KIND_DISCOVERY       = 3'd2;
	localparam kind_t KIND_SERVICE_MISSING = 3'd3;
	localparam kind_t KIND_PAYLOAD_MISSING = 3'd4;
	localparam kind_t KIND_TOO_BIG         = 3'd5;

	localparam class_t CLS_NONE = 2'd0;
	localparam class_t CLS_CONN = 2'd1;
	localparam class_t CLS_NF   = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_CONN_INTERVAL = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CONN_RATE     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CONN_LIMIT    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_NF_INTERVAL   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_NF_RATE       = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_NF_LIMIT      = 3'd5;

	function automatic class_t kind_class(input kind_t kind);
		class_t cls;
		cls = CLS_NONE;
		if (kind == KIND_CONNECT || kind == KIND_DISCOVERY || kind == KIND_PAYLOAD_MISSING) begin
			cls = CLS_CONN;
		end else if (kind == KIND_SERVICE_MISSING || kind == KIND_TOO_BIG) begin
			cls = CLS_NF;
		end
		return cls;
	endfunction

	// counter value after the optional clear
	function automatic logic [DATA_W-1:0] eff_count(input logic [DATA_W-1:0] cnt,
		input logic [DATA_W-1:0] limit);
		logic [DATA_W-1:0] r;
		r = cnt;
		if (limit != '0 && cnt > limit) begin
			r = '0;
		end
		return r;
	endfunction

endpackage

[src/dual_class_exponential_backoff_top.sv]
// top level of the dual-class exponential backoff block
// uses dceb_pkg and assert_macros.svh
//
// channel  dir  handshake          contents
// s        in   s_tvalid/s_tready  tuser err_kind, tdata now_seconds
// m        out  m_tvalid/m_tready  tdata delay_seconds, next_read_time
// apb      in   psel/penable       six 32-bit registers at 4*i
//
// each item uses one shared 32x32 multiplier, which does
// square-and-multiply: a multiply and a square step per failure count bit
// system and unknown kinds skip the multiplier steps
// arst_n clears counters, registers to reset values and the sequencer
// a finished word waits in the output register; the next item is taken meanwhile
`include "assert_macros.svh"

module dual_class_exponential_backoff_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,   // [2:0] err_kind
	input  logic [31:0] s_tdata,   // [31:0] now_seconds
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] delay_seconds, [63:32] next_read_time
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [dceb_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_SQR  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;

	logic [dceb_pkg::DATA_W-1:0] conn_interval_q, conn_rate_q, conn_limit_q;
	logic [dceb_pkg::DATA_W-1:0] nf_interval_q, nf_rate_q, nf_limit_q;
	logic [dceb_pkg::DATA_W-1:0] conn_cnt_q, nf_cnt_q;

	logic [dceb_pkg::DATA_W-1:0] acc_q, base_q, exp_q, now_q;
	logic [dceb_pkg::DATA_W-1:0] delay_q, next_q;
	logic                        m_valid_q;

	logic                        in_acc, cfg_wr, out_load;
	dceb_pkg::class_t            cls;
	logic [dceb_pkg::DATA_W-1:0] conn_eff, nf_eff;
	logic [dceb_pkg::DATA_W-1:0] mul_a, mul_b;
	logic [dceb_pkg::DATA_W-1:0] mul_p;
	logic [dceb_pkg::DATA_W-1:0] sum;
	logic [dceb_pkg::REG_IDX_W-1:0] reg_idx;

	assign pready   = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign reg_idx  = paddr[dceb_pkg::ADDR_W-1:2];
	assign cls      = dceb_pkg::kind_class(s_tuser);
	assign conn_eff = dceb_pkg::eff_count(conn_cnt_q, conn_limit_q);
	assign nf_eff   = dceb_pkg::eff_count(nf_cnt_q, nf_limit_q);
	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_tready);

	// shared multiplier, low word only
	assign mul_a = (state_q == ST_SQR) ? base_q : acc_q;
	assign mul_b = base_q;
	assign mul_p = mul_a * mul_b;
	assign sum   = (now_q + acc_q) & dceb_pkg::TIME_MASK;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			dceb_pkg::REG_CONN_INTERVAL: prdata = conn_interval_q;
			dceb_pkg::REG_CONN_RATE:     prdata = conn_rate_q;
			dceb_pkg::REG_CONN_LIMIT:    prdata = conn_limit_q;
			dceb_pkg::REG_NF_INTERVAL:   prdata = nf_interval_q;
			dceb_pkg::REG_NF_RATE:       prdata = nf_rate_q;
			dceb_pkg::REG_NF_LIMIT:      prdata = nf_limit_q;
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_interval_q <= 32'd1;
			conn_rate_q     <= 32'd2;
			conn_limit_q    <= '0;
			nf_interval_q   <= 32'd1;
			nf_rate_q       <= 32'd2;
			nf_limit_q      <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				dceb_pkg::REG_CONN_INTERVAL: conn_interval_q <= pwdata;
				dceb_pkg::REG_CONN_RATE:     conn_rate_q     <= pwdata;
				dceb_pkg::REG_CONN_LIMIT:    conn_limit_q    <= pwdata;
				dceb_pkg::REG_NF_INTERVAL:   nf_interval_q   <= pwdata;
				dceb_pkg::REG_NF_RATE:       nf_rate_q       <= pwdata;
				dceb_pkg::REG_NF_LIMIT:      nf_limit_q      <= pwdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			conn_cnt_q <= '0;
			nf_cnt_q   <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (cls == dceb_pkg::CLS_CONN) begin
							conn_cnt_q <= conn_eff + 32'd1;
							state_q    <= ST_MUL;
						end else if (cls == dceb_pkg::CLS_NF) begin
							nf_cnt_q <= nf_eff + 32'd1;
							state_q  <= ST_MUL;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL: begin
					state_q <= (exp_q == '0) ? ST_DONE : ST_SQR;
				end
				ST_SQR: begin
					state_q <= ST_MUL;
				end
				ST_DONE: begin
					if (out_load) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: acc starts at interval (zero for no-class kinds), times base for each set exponent bit
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					now_q <= s_tdata;
					if (cls == dceb_pkg::CLS_CONN) begin
						acc_q  <= conn_interval_q;
						base_q <= conn_rate_q;
						exp_q  <= conn_eff;
					end else if (cls == dceb_pkg::CLS_NF) begin
						acc_q  <= nf_interval_q;
						base_q <= nf_rate_q;
						exp_q  <= nf_eff;
					end else begin
						acc_q <= '0;
						exp_q <= '0;
					end
				end
			end
			ST_MUL: begin
				if (exp_q[0]) begin
					acc_q <= mul_p;
				end
			end
			ST_SQR: begin
				base_q <= mul_p;
				exp_q  <= exp_q >> 1;
			end
			ST_DONE: begin
				if (out_load) begin
					delay_q <= acc_q;
					next_q  <= sum;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {next_q, delay_q};

	`DCEB_ASSERT_NEXT(a_none_zero, in_acc && cls == dceb_pkg::CLS_NONE,
		state_q == ST_DONE && acc_q == '0, "no-class kind must give zero delay")
	`DCEB_ASSERT_NEXT(a_conn_keeps_nf, in_acc && cls == dceb_pkg::CLS_CONN,
		$stable(nf_cnt_q), "connection event changed not-found counter")
	`DCEB_ASSERT_NEXT(a_exp_shift, state_q == ST_SQR,
		exp_q == ($past(exp_q) >> 1) && state_q == ST_MUL, "exponent step broken")
	`DCEB_ASSERT_NEXT(a_out_load, out_load,
		m_valid_q && state_q == ST_IDLE, "result not loaded")

endmodule

[dv/dual_class_exponential_backoff_top_test.sv]
// self-checking testbench for dual_class_exponential_backoff_top: directed and random error events
// checked against an in-bench backoff predictor, with register writes over apb between phases
// depends on dceb_pkg and the rtl top level only
module dual_class_exponential_backoff_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 80;
	localparam int BLOCKS_PER_PHASE = 5;
	localparam int EVENTS_PER_BLOCK = 128;
	localparam logic [dceb_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [dceb_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [31:0] next_read;
		logic [31:0] delay;
	} backoff_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [2:0]  s_tuser = '0;   // [2:0] err_kind
	logic [31:0] s_tdata = '0;   // [31:0] now_seconds
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;        // [31:0] delay_seconds, [63:32] next_read_time
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [dceb_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	backoff_t pending_backoff[$];
	int mismatch_count = 0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;

	logic [31:0] interval_by_class [dceb_pkg::CLS_CONN:dceb_pkg::CLS_NF];
	logic [31:0] rate_by_class [dceb_pkg::CLS_CONN:dceb_pkg::CLS_NF];
	logic [31:0] limit_by_class [dceb_pkg::CLS_CONN:dceb_pkg::CLS_NF];
	logic [31:0] fails_by_class [dceb_pkg::CLS_CONN:dceb_pkg::CLS_NF];

	dual_class_exponential_backoff_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= arst_n && ($urandom_range(0, 99) >= sink_stall_pct);
	end

	function automatic logic [31:0] power_wrap(input logic [31:0] base, input logic [31:0] expo);
		logic [31:0] acc;
		logic [31:0] b;
		logic [31:0] e;
		acc = 32'd1;
		b = base;
		e = expo;
		while (e != 0) begin
			if (e[0]) begin
				acc = acc * b;
			end
			b = b * b;
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic logic [31:0] class_backoff(input dceb_pkg::class_t cls);
		logic [31:0] delay;
		if (limit_by_class[cls] != 0 && fails_by_class[cls] > limit_by_class[cls]) begin
			fails_by_class[cls] = '0;
		end
		delay = interval_by_class[cls] * power_wrap(rate_by_class[cls], fails_by_class[cls]);
		fails_by_class[cls] = fails_by_class[cls] + 32'd1;
		return delay;
	endfunction

	function automatic void predict_backoff(input dceb_pkg::kind_t kind, input logic [31:0] now);
		backoff_t want;
		case (kind)
			dceb_pkg::KIND_CONNECT, dceb_pkg::KIND_DISCOVERY,
			dceb_pkg::KIND_PAYLOAD_MISSING: begin
				want.delay = class_backoff(dceb_pkg::CLS_CONN);
			end
			dceb_pkg::KIND_SERVICE_MISSING, dceb_pkg::KIND_TOO_BIG: begin
				want.delay = class_backoff(dceb_pkg::CLS_NF);
			end
			default: begin
				want.delay = '0;
			end
		endcase
		want.next_read = (now + want.delay) & dceb_pkg::TIME_MASK;
		pending_backoff.push_back(want);
	endfunction

	function automatic void store_reg(input logic [dceb_pkg::REG_IDX_W-1:0] idx,
		input logic [31:0] value);
		case (idx)
			dceb_pkg::REG_CONN_INTERVAL: interval_by_class[dceb_pkg::CLS_CONN] = value;
			dceb_pkg::REG_CONN_RATE: rate_by_class[dceb_pkg::CLS_CONN] = value;
			dceb_pkg::REG_CONN_LIMIT: limit_by_class[dceb_pkg::CLS_CONN] = value;
			dceb_pkg::REG_NF_INTERVAL: interval_by_class[dceb_pkg::CLS_NF] = value;
			dceb_pkg::REG_NF_RATE: rate_by_class[dceb_pkg::CLS_NF] = value;
			dceb_pkg::REG_NF_LIMIT: limit_by_class[dceb_pkg::CLS_NF] = value;
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] shadow_reg(input logic [dceb_pkg::REG_IDX_W-1:0] idx);
		logic [31:0] value;
		case (idx)
			dceb_pkg::REG_CONN_INTERVAL: value = interval_by_class[dceb_pkg::CLS_CONN];
			dceb_pkg::REG_CONN_RATE: value = rate_by_class[dceb_pkg::CLS_CONN];
			dceb_pkg::REG_CONN_LIMIT: value = limit_by_class[dceb_pkg::CLS_CONN];
			dceb_pkg::REG_NF_INTERVAL: value = interval_by_class[dceb_pkg::CLS_NF];
			dceb_pkg::REG_NF_RATE: value = rate_by_class[dceb_pkg::CLS_NF];
			dceb_pkg::REG_NF_LIMIT: value = limit_by_class[dceb_pkg::CLS_NF];
			default: value = '0;
		endcase
		return value;
	endfunction

	always @(negedge clk) begin : check_words
		backoff_t got;
		backoff_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_backoff.size() == 0) begin
				$error("unexpected word: delay_seconds %h next_read_time %h",
					got.delay, got.next_read);
				mismatch_count++;
			end else begin
				want = pending_backoff.pop_front();
				if (got.delay !== want.delay) begin
					$error("delay_seconds: expected %h, actual %h", want.delay, got.delay);
					mismatch_count++;
				end
				if (got.next_read !== want.next_read) begin
					$error("next_read_time: expected %h, actual %h",
						want.next_read, got.next_read);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_event(input dceb_pkg::kind_t kind, input logic [31:0] now);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= now;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		predict_backoff(kind, now);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_backoff.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [dceb_pkg::REG_IDX_W-1:0] idx,
		input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		store_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_read_check(input logic [dceb_pkg::REG_IDX_W-1:0] idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		if (prdata !== shadow_reg(idx)) begin
			$error("prdata at register %0d: expected %h, actual %h", idx, shadow_reg(idx),
				prdata);
			mismatch_count++;
		end
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_all_regs();
		for (int i = dceb_pkg::REG_CONN_INTERVAL; i <= dceb_pkg::REG_NF_LIMIT; i++) begin
			apb_read_check(dceb_pkg::REG_IDX_W'(i));
		end
	endtask

	task automatic test_reset_defaults();
		read_all_regs();
		repeat (3) send_event(dceb_pkg::KIND_CONNECT, $urandom);
		repeat (2) send_event(dceb_pkg::KIND_TOO_BIG, $urandom);
	endtask

	task automatic test_kind_map();
		for (int k = 0; k < 8; k++) begin
			send_event(dceb_pkg::kind_t'(k), $urandom);
		end
	endtask

	task automatic test_zero_rate_and_clear();
		wait_drained();
		apb_write(dceb_pkg::REG_CONN_INTERVAL, 32'd7);
		apb_write(dceb_pkg::REG_CONN_RATE, 32'd0);
		apb_write(dceb_pkg::REG_CONN_LIMIT, 32'd1);
		send_event(dceb_pkg::KIND_DISCOVERY, 32'd0);
		send_event(dceb_pkg::KIND_PAYLOAD_MISSING, 32'd100);
	endtask

	task automatic test_wide_values();
		wait_drained();
		apb_write(dceb_pkg::REG_NF_INTERVAL, 32'hFFFF_FFFF);
		apb_write(dceb_pkg::REG_NF_RATE, 32'hFFFF_FFFF);
		apb_write(dceb_pkg::REG_NF_LIMIT, 32'hFFFF_FFFF);
		apb_write(dceb_pkg::REG_CONN_INTERVAL, 32'd0);
		apb_write(dceb_pkg::REG_CONN_RATE, 32'hFFFF_FFFF);
		send_event(dceb_pkg::KIND_SERVICE_MISSING, 32'hFFFF_FFFF);
		send_event(dceb_pkg::KIND_TOO_BIG, 32'hFFFF_FFF0);
		send_event(dceb_pkg::KIND_SYSTEM, 32'hFFFF_FFFF);
		send_event(dceb_pkg::KIND_CONNECT, 32'hFFFF_FFFF);
	endtask

	task automatic test_unused_regs();
		wait_drained();
		apb_write(REG_SPARE_LO, $urandom);
		apb_write(REG_SPARE_HI, $urandom);
		read_all_regs();
		send_event(dceb_pkg::KIND_DISCOVERY, $urandom);
		send_event(dceb_pkg::KIND_SERVICE_MISSING, $urandom);
	endtask

	function automatic logic [31:0] pick_interval();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return 32'd1;
			2: return $urandom_range(2, 1000);
			3: return $urandom;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] pick_rate();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'd2;
			3: return $urandom_range(3, 9);
			4: return $urandom;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] pick_limit();
		case ($urandom_range(0, 4))
			0: return 32'd0;
			1: return $urandom_range(1, 8);
			2: return $urandom_range(9, 64);
			3: return $urandom;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic logic [31:0] pick_now();
		case ($urandom_range(0, 5))
			4: return 32'hFFFF_FFFF - $urandom_range(0, 255);
			5: return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_random_traffic(input int blocks, input int per_block);
		for (int b = 0; b < blocks; b++) begin
			wait_drained();
			apb_write(dceb_pkg::REG_CONN_INTERVAL, pick_interval());
			apb_write(dceb_pkg::REG_CONN_RATE, pick_rate());
			apb_write(dceb_pkg::REG_CONN_LIMIT, pick_limit());
			apb_write(dceb_pkg::REG_NF_INTERVAL, pick_interval());
			apb_write(dceb_pkg::REG_NF_RATE, pick_rate());
			apb_write(dceb_pkg::REG_NF_LIMIT, pick_limit());
			for (int i = 0; i < per_block; i++) begin
				send_event(dceb_pkg::kind_t'($urandom_range(0, 7)), pick_now());
			end
		end
	endtask

	initial begin
		interval_by_class[dceb_pkg::CLS_CONN] = 32'd1;
		rate_by_class[dceb_pkg::CLS_CONN] = 32'd2;
		limit_by_class[dceb_pkg::CLS_CONN] = 32'd0;
		fails_by_class[dceb_pkg::CLS_CONN] = 32'd0;
		interval_by_class[dceb_pkg::CLS_NF] = 32'd1;
		rate_by_class[dceb_pkg::CLS_NF] = 32'd2;
		limit_by_class[dceb_pkg::CLS_NF] = 32'd0;
		fails_by_class[dceb_pkg::CLS_NF] = 32'd0;
		src_idle_pct = 17;
		sink_stall_pct = 59;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_kind_map();
		test_zero_rate_and_clear();
		test_wide_values();
		test_unused_regs();

		test_random_traffic(BLOCKS_PER_PHASE, EVENTS_PER_BLOCK);
		src_idle_pct = 59;
		sink_stall_pct = 17;
		test_random_traffic(BLOCKS_PER_PHASE, EVENTS_PER_BLOCK);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		test_random_traffic(BLOCKS_PER_PHASE, EVENTS_PER_BLOCK);

		wait_drained();
		if (mismatch_count == 0 && pending_backoff.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#15_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
